// ----- sv/dmsp_pkg.sv -----
// Shared types and constants for the dense shortest-path block.
package dmsp_pkg;

  localparam int unsigned DIST_W  = 20;
  localparam int unsigned KEY_W   = DIST_W + 1;
  localparam int unsigned NODE_FW = 4;
  localparam int unsigned WIN_W   = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  // Key of an unreached node: one above any reachable distance.
  localparam logic [KEY_W-1:0]  KEY_UNREACHED = {1'b1, {DIST_W{1'b0}}};
  localparam logic [KEY_W-1:0]  KEY_INIT      = {KEY_W{1'b1}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Outcome of relaxing one edge.
  typedef struct packed {
    logic              upd;
    logic [DIST_W-1:0] dnew;
  } relax_t;

endpackage

// ----- sv/dmsp_relax.sv -----
// Edge relaxation unit: saturating add and compare against the stored distance.
module dmsp_relax #(
  parameter int unsigned WEIGHT_W = 16
) (
  input  logic [dmsp_pkg::DIST_W-1:0] du_i,
  input  logic [WEIGHT_W-1:0]         w_i,
  input  logic [dmsp_pkg::DIST_W-1:0] dv_i,
  input  logic                        settled_i,
  input  logic                        reached_i,
  output dmsp_pkg::relax_t            res_o
);
  import dmsp_pkg::*;

  logic [KEY_W-1:0]  sum;
  logic [DIST_W-1:0] cand;

  assign sum  = {1'b0, du_i} + KEY_W'(w_i);
  assign cand = sum[KEY_W-1] ? DIST_MAX : sum[DIST_W-1:0];

  assign res_o.dnew = cand;
  assign res_o.upd  = !settled_i && (w_i != '0) && (!reached_i || (cand < dv_i));

endmodule

// ----- sv/dense_matrix_shortest_path.sv -----
// Dense single-source shortest path over a stored adjacency matrix.
// Load beat: busy stays low. Run beat: up to NODES rounds of a minimum scan and a row
// relax, then an output walk; a source out of range skips straight to the walk.
// Last result beat shows in the first idle cycle; results are one per cycle, no stall.
// Reset: a clearing pass zeroes the weight memory, busy high.
module dense_matrix_shortest_path #(
  parameter int unsigned NODES       = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op_i,
  input  logic [dmsp_pkg::NODE_FW-1:0] row_i,
  input  logic [dmsp_pkg::NODE_FW-1:0] col_i,
  input  logic [dmsp_pkg::WIN_W-1:0]   weight_i,
  input  logic [dmsp_pkg::NODE_FW-1:0] source_i,
  output logic                         valid_o,
  output logic [dmsp_pkg::NODE_FW-1:0] node_o,
  output logic [dmsp_pkg::DIST_W-1:0]  distance_o,
  output logic                         reachable_o,
  output logic                         last_o
);
  import dmsp_pkg::*;

  // Node index width and memory sizes.
  localparam int unsigned NW     = $clog2(NODES);
  localparam int unsigned MW     = (WEIGHT_BITS < WIN_W) ? WEIGHT_BITS : WIN_W;
  localparam int unsigned WDEPTH = 1 << (2 * NW);
  localparam int unsigned DDEPTH = 1 << NW;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_RELAX = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [NW:0]       k_q, k_d;          // node walk counter, 0..NODES
  logic [NW:0]       round_q, round_d;  // settled rounds
  logic [2*NW-1:0]   clr_q, clr_d;      // clearing pass address
  logic [NODES-1:0]  settled_q, settled_d;
  logic [NODES-1:0]  reached_q, reached_d;
  logic [KEY_W-1:0]  best_q, best_d;
  logic [NW-1:0]     idx_q, idx_d;
  logic [NW-1:0]     u_q, u_d;
  logic [DIST_W-1:0] du_q, du_d;

  // Result register.
  logic                valid_q, valid_d;
  logic [NODE_FW-1:0]  node_q, node_d;
  logic [DIST_W-1:0]   dist_q, dist_d;
  logic                reach_q, reach_d;
  logic                last_q, last_d;

  // Weight matrix memory: one write port, one registered read port.
  logic [MW-1:0]     wmem [WDEPTH];
  logic [MW-1:0]     wrd_q;
  logic              w_we;
  logic [2*NW-1:0]   w_addr;
  logic [MW-1:0]     w_wd;
  logic [2*NW-1:0]   w_ra;

  // Distance memory: one write port, one registered read port, indexed by node.
  logic [DIST_W-1:0] dmem [DDEPTH];
  logic [DIST_W-1:0] drd_q;
  logic              d_we;
  logic [NW-1:0]     d_addr;
  logic [DIST_W-1:0] d_wd;
  logic [NW-1:0]     d_ra;

  // Input decode; narrow node fields are widened so any NODES compares cleanly.
  logic              acc;
  logic [NW+3:0]     row_x, col_x, src_x;
  logic              wr_in_range, src_in_range;

  // Data returned from the memories belongs to the node one behind k_q.
  logic [NW:0]       km1;
  logic [NW-1:0]     pv;
  logic [NW+3:0]     pv_x;
  logic              k_last;

  // Minimum search.
  logic [KEY_W-1:0]  key;
  logic              take;
  logic [KEY_W-1:0]  sel_best;
  logic [NW-1:0]     sel_idx;

  relax_t            rlx;

  assign acc   = start && !busy;
  assign row_x = {{NW{1'b0}}, row_i};
  assign col_x = {{NW{1'b0}}, col_i};
  assign src_x = {{NW{1'b0}}, source_i};
  assign wr_in_range  = (row_x < (NW+4)'(NODES)) && (col_x < (NW+4)'(NODES));
  assign src_in_range = src_x < (NW+4)'(NODES);

  assign km1    = k_q - 1'b1;
  assign pv     = km1[NW-1:0];
  assign pv_x   = {{4{1'b0}}, pv};
  assign k_last = (k_q == (NW+1)'(NODES));

  assign key      = reached_q[pv] ? {1'b0, drd_q} : KEY_UNREACHED;
  assign take     = (k_q != '0) && !settled_q[pv] && (key <= best_q);
  assign sel_best = take ? key : best_q;
  assign sel_idx  = take ? pv : idx_q;

  assign w_ra = {u_q, k_q[NW-1:0]};
  assign d_ra = k_q[NW-1:0];

  dmsp_relax #(
    .WEIGHT_W (MW)
  ) u_relax (
    .du_i      (du_q),
    .w_i       (wrd_q),
    .dv_i      (drd_q),
    .settled_i (settled_q[pv]),
    .reached_i (reached_q[pv]),
    .res_o     (rlx)
  );

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    round_d   = round_q;
    clr_d     = clr_q;
    settled_d = settled_q;
    reached_d = reached_q;
    best_d    = best_q;
    idx_d     = idx_q;
    u_d       = u_q;
    du_d      = du_q;
    valid_d   = 1'b0;
    node_d    = node_q;
    dist_d    = dist_q;
    reach_d   = reach_q;
    last_d    = last_q;
    w_we      = 1'b0;
    w_addr    = {row_x[NW-1:0], col_x[NW-1:0]};
    w_wd      = weight_i[MW-1:0];
    d_we      = 1'b0;
    d_addr    = src_x[NW-1:0];
    d_wd      = '0;

    unique case (state_q)
      S_CLEAR: begin
        w_we   = 1'b1;
        w_addr = clr_q;
        w_wd   = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == {(2*NW){1'b1}}) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (acc && (op_i == OP_LOAD)) begin
          w_we = wr_in_range;
        end else if (acc && (op_i == OP_RUN)) begin
          settled_d = '0;
          reached_d = '0;
          k_d       = '0;
          round_d   = '0;
          best_d    = KEY_INIT;
          idx_d     = '0;
          if (src_in_range) begin
            reached_d[src_x[NW-1:0]] = 1'b1;
            d_we    = 1'b1;
            state_d = S_SCAN;
          end else begin
            state_d = S_OUT;
          end
        end
      end

      S_SCAN: begin
        k_d    = k_q + 1'b1;
        best_d = sel_best;
        idx_d  = sel_idx;
        if (k_last) begin
          k_d                = '0;
          best_d             = KEY_INIT;
          idx_d              = '0;
          u_d                = sel_idx;
          du_d               = sel_best[DIST_W-1:0];
          settled_d[sel_idx] = 1'b1;
          round_d            = round_q + 1'b1;
          // Once the nearest open node is unreached, nothing can change.
          if (reached_q[sel_idx]) begin
            state_d = S_RELAX;
          end else begin
            state_d = S_OUT;
          end
        end
      end

      S_RELAX: begin
        k_d = k_q + 1'b1;
        if ((k_q != '0) && rlx.upd) begin
          d_we          = 1'b1;
          d_addr        = pv;
          d_wd          = rlx.dnew;
          reached_d[pv] = 1'b1;
        end
        if (k_last) begin
          k_d = '0;
          if (round_q == (NW+1)'(NODES)) begin
            state_d = S_OUT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_OUT: begin
        k_d = k_q + 1'b1;
        if (k_q != '0) begin
          valid_d = 1'b1;
          node_d  = pv_x[NODE_FW-1:0];
          dist_d  = reached_q[pv] ? drd_q : DIST_MAX;
          reach_d = reached_q[pv];
          last_d  = k_last;
        end
        if (k_last) begin
          k_d     = '0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      k_q       <= '0;
      round_q   <= '0;
      clr_q     <= '0;
      settled_q <= '0;
      reached_q <= '0;
      best_q    <= KEY_INIT;
      idx_q     <= '0;
      u_q       <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      round_q   <= round_d;
      clr_q     <= clr_d;
      settled_q <= settled_d;
      reached_q <= reached_d;
      best_q    <= best_d;
      idx_q     <= idx_d;
      u_q       <= u_d;
      valid_q   <= valid_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    du_q    <= du_d;
    node_q  <= node_d;
    dist_q  <= dist_d;
    reach_q <= reach_d;
    last_q  <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem[w_addr] <= w_wd;
    end
    wrd_q <= wmem[w_ra];
  end

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      dmem[d_addr] <= d_wd;
    end
    drd_q <= dmem[d_ra];
  end

  assign busy        = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign node_o      = node_q;
  assign distance_o  = dist_q;
  assign reachable_o = reach_q;
  assign last_o      = last_q;

`ifndef SYNTH
  // A result beat only follows a cycle of the output walk.
  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == S_OUT))
    else $error("result beat outside output walk");

  // The result stream has no gaps until the last beat.
  a_stream_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> valid_o)
    else $error("gap in result stream");

  // A row is relaxed only for a settled node that was reached.
  a_relax_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RELAX) |-> (settled_q[u_q] && reached_q[u_q]))
    else $error("relaxing row of unsettled or unreached node");

  // A run beat makes the block busy on the next cycle.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_RUN)) |=> busy)
    else $error("run beat did not start the sequencer");
`endif

endmodule
